// ----- sv/twrr_pkg.sv -----
// twrr_pkg: shared types, constants and helpers for the time window record ring.
// No dependencies; imported by every module of the block.
`default_nettype none

package twrr_pkg;

  localparam int DEPTH   = 64;
  localparam int MAX_LEN = 512;

  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int STAMP_W = 32;
  localparam int LEN_W   = 10;
  localparam int HDL_W   = 32;
  localparam int POS_W   = 6;
  localparam int DUR_W   = 31;
  localparam int CAP_W   = 7;
  localparam int CFG_W   = 31;
  localparam int CIDX_W  = 1;

  // operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_ORDER   = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_DURATION = 1'd0;
  localparam logic [CIDX_W-1:0] REG_CAPACITY = 1'd1;

  localparam logic [DUR_W-1:0] DURATION_RST = DUR_W'(1000000);
  localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(DEPTH);

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [LEN_W-1:0]   length;
    logic [HDL_W-1:0]   handle;
  } rec_t;

  typedef struct packed {
    logic expired;   // age has reached the window duration
    logic backward;  // wrapping difference is 2^31 or more
  } age_flags_t;

  // ring slot of an age index; oldest < cap and idx <= cap keep the sum below 2*cap
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] oldest,
                                               input logic [CNT_W-1:0]  idx,
                                               input logic [CNT_W-1:0]  cap);
    logic [CNT_W:0] sum;
    sum = {2'b00, oldest} + {1'b0, idx};
    if (sum >= {1'b0, cap}) begin
      sum = sum - {1'b0, cap};
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/twrr_store.sv -----
// twrr_store: record storage, one write port and one registered read port.
// Depends on twrr_pkg for the record type and depth.
`default_nettype none

module twrr_store (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [twrr_pkg::SLOT_W-1:0] wr_addr,
  input  wire twrr_pkg::rec_t           wr_data,
  input  wire logic [twrr_pkg::SLOT_W-1:0] rd_addr,
  output twrr_pkg::rec_t                rd_data
);
  import twrr_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- sv/twrr_age_unit.sv -----
// twrr_age_unit: shared wrapping subtract and compare for record ages.
// Depends on twrr_pkg for widths and the flag struct.
`default_nettype none

module twrr_age_unit (
  input  wire logic [twrr_pkg::STAMP_W-1:0] now,
  input  wire logic [twrr_pkg::STAMP_W-1:0] rec_stamp,
  input  wire logic [twrr_pkg::DUR_W-1:0]   duration,
  output twrr_pkg::age_flags_t              flags
);
  import twrr_pkg::*;

  logic [STAMP_W-1:0] diff;
  logic [DUR_W-1:0]   dur_eff;

  always_comb begin
    diff    = now - rec_stamp;
    dur_eff = (duration == '0) ? DUR_W'(1) : duration;
    flags.expired  = (diff >= {1'b0, dur_eff});
    flags.backward = diff[STAMP_W-1];
  end

endmodule

`default_nettype wire

// ----- sv/time_window_record_ring.sv -----
// time_window_record_ring: top level, sequencer and state of the record ring.
// Depends on twrr_pkg, twrr_store and twrr_age_unit.
`default_nettype none

// A command is taken when start is high and busy is low; busy stays high until
// the answer is out. The answer is one beat: done is high for exactly one cycle
// with status, occupancy, drop_total and the read fields, and the receiver
// cannot hold it off. Records live in a 64-entry memory with a registered read,
// and a single age unit compares one record per cycle. A push or an expire
// retires expired records from the oldest end, up to the capacity in use;
// retiring every record skips the final compare. Write configuration only
// while busy is low and no command is starting; a write of capacity_in_use
// empties the ring but keeps drop_total.
module time_window_record_ring (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    op,
  input  wire logic [twrr_pkg::STAMP_W-1:0]  stamp,
  input  wire logic [twrr_pkg::LEN_W-1:0]    length,
  input  wire logic [twrr_pkg::HDL_W-1:0]    payload_handle,
  input  wire logic [twrr_pkg::POS_W-1:0]    position,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [twrr_pkg::CNT_W-1:0]         occupancy,
  output logic [31:0]                        drop_total,
  output logic [twrr_pkg::STAMP_W-1:0]       read_stamp,
  output logic [twrr_pkg::LEN_W-1:0]         read_length,
  output logic [twrr_pkg::HDL_W-1:0]         read_handle,
  input  wire logic                          cfg_write,
  input  wire logic [twrr_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [twrr_pkg::CFG_W-1:0]    cfg_data
);
  import twrr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECODE  = 6'b000010,
    S_READ    = 6'b000100,
    S_ORDER   = 6'b001000,
    S_EXP_CHK = 6'b010000,
    S_WRITE   = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [DUR_W-1:0] duration;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] cap_eff;

  // ring state
  logic [SLOT_W-1:0] oldest, oldest_next, oldest_inc;
  logic [CNT_W-1:0]  held, held_next;
  logic [31:0]       drop_count, drop_next;

  // latched command
  logic [1:0]         op_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [LEN_W-1:0]   length_q;
  logic [HDL_W-1:0]   handle_q;
  logic [POS_W-1:0]   position_q;

  // memory and age unit hookup
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr, rd_addr;
  rec_t              wr_data, rd_data;
  age_flags_t        age;

  // result staging
  logic       finish;
  logic [1:0] fin_status;
  logic       fin_read;
  logic       bad_len;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (capacity > CAP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = capacity;
    end
  end

  // next oldest slot with wrap at the capacity in use
  assign oldest_inc = ({1'b0, oldest} + CNT_W'(1) >= cap_eff) ? '0 : oldest + SLOT_W'(1);

  assign bad_len = (length_q == '0) || (length_q > LEN_W'(MAX_LEN)) || length_q[0];

  assign wr_data = '{stamp: stamp_q, length: length_q, handle: handle_q};

  twrr_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  twrr_age_unit u_age (
    .now       (stamp_q),
    .rec_stamp (rd_data.stamp),
    .duration  (duration),
    .flags     (age)
  );

  // sequencer
  always_comb begin
    state_next  = state;
    oldest_next = oldest;
    held_next   = held;
    drop_next   = drop_count;
    rd_addr     = oldest;
    wr_en       = 1'b0;
    wr_addr     = oldest;
    finish      = 1'b0;
    fin_status  = ST_OK;
    fin_read    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_q)
          OP_PUSH: begin
            if (bad_len) begin
              finish     = 1'b1;
              fin_status = ST_BAD_LEN;
              state_next = S_IDLE;
            end else if (held != '0) begin
              // fetch the newest record for the time order check
              rd_addr    = slot_of(oldest, held - CNT_W'(1), cap_eff);
              state_next = S_ORDER;
            end else begin
              state_next = S_WRITE;
            end
          end
          OP_READ: begin
            if ({1'b0, position_q} >= held) begin
              finish     = 1'b1;
              fin_status = ST_RANGE;
              state_next = S_IDLE;
            end else begin
              rd_addr    = slot_of(oldest, {1'b0, position_q}, cap_eff);
              state_next = S_READ;
            end
          end
          OP_EXPIRE: begin
            if (held != '0) begin
              state_next = S_EXP_CHK;
            end else begin
              finish     = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_CLEAR: begin
            held_next   = '0;
            oldest_next = '0;
            drop_next   = '0;
            finish      = 1'b1;
            state_next  = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        finish     = 1'b1;
        fin_read   = 1'b1;
        state_next = S_IDLE;
      end
      S_ORDER: begin
        if (age.backward) begin
          finish     = 1'b1;
          fin_status = ST_ORDER;
          state_next = S_IDLE;
        end else begin
          state_next = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        // rd_data holds the oldest record; retire it if old enough and
        // fetch its successor in the same cycle
        if (age.expired) begin
          oldest_next = oldest_inc;
          held_next   = held - CNT_W'(1);
          rd_addr     = oldest_inc;
        end
        if (!age.expired || held == CNT_W'(1)) begin
          if (op_q == OP_PUSH) begin
            state_next = S_WRITE;
          end else begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_WRITE: begin
        wr_en = 1'b1;
        if (held >= cap_eff) begin
          // full: overwrite the oldest record and count the drop
          wr_addr     = oldest;
          oldest_next = oldest_inc;
          drop_next   = drop_count + 32'd1;
        end else begin
          wr_addr   = slot_of(oldest, held, cap_eff);
          held_next = held + CNT_W'(1);
        end
        finish     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      oldest     <= '0;
      held       <= '0;
      drop_count <= '0;
      duration   <= DURATION_RST;
      capacity   <= CAPACITY_RST;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      drop_count <= drop_next;
      done       <= finish;
      if (cfg_write && cfg_index == REG_CAPACITY) begin
        capacity <= cfg_data[CAP_W-1:0];
        held     <= '0;
        oldest   <= '0;
      end else begin
        held   <= held_next;
        oldest <= oldest_next;
      end
      if (cfg_write && cfg_index == REG_DURATION) begin
        duration <= cfg_data[DUR_W-1:0];
      end
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op;
      stamp_q    <= stamp;
      length_q   <= length;
      handle_q   <= payload_handle;
      position_q <= position;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (finish) begin
      status     <= fin_status;
      occupancy  <= held_next;
      drop_total <= drop_next;
      if (fin_read) begin
        read_stamp  <= rd_data.stamp;
        read_length <= rd_data.length;
        read_handle <= rd_data.handle;
      end else begin
        read_stamp  <= '0;
        read_length <= '0;
        read_handle <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/twrr_checker.sv -----
// twrr_checker: port-level checks on the record ring, bound to the top level.
// Depends on twrr_pkg and time_window_record_ring.
`default_nettype none

module twrr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done,
  input wire logic [1:0]                   status,
  input wire logic [twrr_pkg::CNT_W-1:0]   occupancy,
  input wire logic [twrr_pkg::STAMP_W-1:0] read_stamp,
  input wire logic [twrr_pkg::LEN_W-1:0]   read_length,
  input wire logic [twrr_pkg::HDL_W-1:0]   read_handle
);
  import twrr_pkg::*;

  // a taken command holds off the next one and does not answer in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("command accepted without going busy");

  // the answer beat coincides with the return to ready
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= CNT_W'(DEPTH)))
    else $error("occupancy above ring depth");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_RANGE) |->
      (read_stamp == '0 && read_length == '0 && read_handle == '0))
    else $error("out-of-range read returned record data");

endmodule

bind time_window_record_ring twrr_checker u_twrr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .occupancy   (occupancy),
  .read_stamp  (read_stamp),
  .read_length (read_length),
  .read_handle (read_handle)
);

`default_nettype wire
